// File: src/jhe_pkg.sv
// jhe_pkg: shared types and constants for the json html/js escaper
// no dependencies; used by jhe_front, jhe_queue, jhe_back and the top level
package jhe_pkg;

   // bytes of one expanded job: two held prefix bytes plus a six-byte escape
   localparam int JOB_BYTES = 8;
   localparam int JOB_CNT_W = 4;
   localparam int JOB_IDX_W = 3;

   // default depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HTML_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_JS_ENABLE   = 1'd1;

   // held utf-8 prefix
   typedef enum logic [2:0] {
      HELD_NONE  = 3'b001,
      HELD_E2    = 3'b010,
      HELD_E2_80 = 3'b100
   } held_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_final;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       string_end;
      logic       changed;
   } rsp_type;

   // one input item expanded into its output bytes
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] data;
      logic [JOB_CNT_W-1:0]      count;
      logic                      fin;
      logic                      changed;
   } job_type;

   typedef struct packed {
      held_type held;
      logic     any_escaped;
   } front_status_type;

endpackage

// File: src/json_html_js_escaper_core.sv
// json_html_js_escaper_core: top level of the json string escaper for html/js embedding
// depends on jhe_pkg, jhe_front, jhe_queue, jhe_back
//
//   channel   ports                           direction  handshake
//   request   push, full, req_item            in         accepted on push && !full
//   response  empty, pop, rsp_item            out        accepted on pop && !empty
//   csr       csr_wr_en, csr_index, csr_wdata in         written on csr_wr_en
//
// an item is accepted in the cycle it is offered unless the job queue is full;
// the front expands it in that same cycle into 0 to 8 output bytes
// the back sends one output byte per cycle while pop is held, so plain bytes flow at
// one item per cycle; an escape yields six bytes (eight with a broken prefix)
// full rises only once QueueDepth expanded items are waiting on the output
// reset is synchronous: queue empty, nothing held, both escapes enabled
module json_html_js_escaper_core #(
   parameter int QueueDepth = jhe_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  jhe_pkg::req_type                   req_item,
   output logic                               empty,
   input  logic                               pop,
   output jhe_pkg::rsp_type                   rsp_item,
   input  logic                               csr_wr_en,
   input  logic [jhe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [jhe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int LevelW = $clog2(QueueDepth + 1);

   // configuration registers
   logic html_enable_ff, html_enable_in;
   logic js_enable_ff, js_enable_in;

   logic                      accept;
   logic                      job_push;
   jhe_pkg::job_type          front_job;
   jhe_pkg::front_status_type front_status;
   jhe_pkg::job_type          head_job;
   logic                      head_valid;
   logic                      head_pop;
   logic [LevelW-1:0]         q_level;

   always_comb begin
      html_enable_in = html_enable_ff;
      js_enable_in   = js_enable_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            jhe_pkg::CSR_HTML_ENABLE: html_enable_in = csr_wdata[0];
            jhe_pkg::CSR_JS_ENABLE:   js_enable_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         html_enable_ff <= 1'b1;
         js_enable_ff   <= 1'b1;
      end else begin
         html_enable_ff <= html_enable_in;
         js_enable_ff   <= js_enable_in;
      end
   end

   // front takes an item whenever the queue has room
   assign accept = push && !full;

   jhe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .html_enable (html_enable_ff),
      .js_enable   (js_enable_ff),
      .accept      (accept),
      .req_item    (req_item),
      .job_push    (job_push),
      .job         (front_job),
      .status      (front_status)
   );

   // expanded items wait here; items with no output bytes never enter
   jhe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (front_job),
      .pop        (head_pop),
      .head_job   (head_job),
      .head_valid (head_valid),
      .full       (full),
      .level      (q_level)
   );

   // back serializes the head job, releasing it on its last byte
   jhe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .pop        (pop),
      .empty      (empty),
      .rsp_item   (rsp_item)
   );

   // queue occupancy stays within its depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= LevelW'(QueueDepth))
      else $error("job queue level exceeds depth");

   // a string end always closes the run of its item
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.string_end) |-> rsp_item.run_end)
      else $error("string_end without run_end");

   // changed only shows on the string end
   a_changed_at_end: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.changed) |-> rsp_item.string_end)
      else $error("changed outside string end");

   // a final byte leaves nothing held and the escape flag cleared
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.in_final) |=>
      (front_status.held == jhe_pkg::HELD_NONE && !front_status.any_escaped))
      else $error("state not cleared after final byte");

endmodule

// File: src/jhe_front.sv
// jhe_front: accepts input items, tracks the held prefix and expands each item into a job
// depends on jhe_pkg
module jhe_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      html_enable,
   input  logic                      js_enable,
   input  logic                      accept,
   input  jhe_pkg::req_type          req_item,
   output logic                      job_push,
   output jhe_pkg::job_type          job,
   output jhe_pkg::front_status_type status
);

   localparam logic [7:0] B_E2     = 8'hE2;
   localparam logic [7:0] B_80     = 8'h80;
   localparam logic [7:0] B_A8     = 8'hA8;
   localparam logic [7:0] B_A9     = 8'hA9;
   localparam logic [7:0] B_LT     = 8'h3C;
   localparam logic [7:0] B_GT     = 8'h3E;
   localparam logic [7:0] B_AMP    = 8'h26;
   localparam logic [7:0] B_BSLASH = 8'h5C;
   localparam logic [7:0] B_U      = 8'h75;
   localparam logic [7:0] D_0      = 8'h30;
   localparam logic [7:0] D_2      = 8'h32;
   localparam logic [7:0] D_3      = 8'h33;
   localparam logic [7:0] D_6      = 8'h36;
   localparam logic [7:0] D_8      = 8'h38;
   localparam logic [7:0] D_9      = 8'h39;
   localparam logic [7:0] D_C      = 8'h63;
   localparam logic [7:0] D_E      = 8'h65;

   jhe_pkg::held_type held_ff, held_in, held_mid;
   logic              any_ff, any_in;

   logic [7:0] c;
   logic       fin;
   logic       esc;
   logic       literal;
   logic [7:0] d0, d1, d2, d3;
   logic [jhe_pkg::JOB_BYTES-1:0][7:0] data;
   logic [jhe_pkg::JOB_CNT_W-1:0]      n;

   assign c   = req_item.in_byte;
   assign fin = req_item.in_final;

   // classify the byte against the held prefix
   always_comb begin
      held_mid = held_ff;
      esc      = 1'b0;
      literal  = 1'b0;
      d0 = D_0;
      d1 = D_0;
      d2 = D_2;
      d3 = D_6;
      data = '0;
      n    = '0;
      if (held_ff == jhe_pkg::HELD_E2 && js_enable && c == B_80) begin
         held_mid = jhe_pkg::HELD_E2_80;
      end else if (held_ff == jhe_pkg::HELD_E2_80 && js_enable &&
                   (c == B_A8 || c == B_A9)) begin
         held_mid = jhe_pkg::HELD_NONE;
         esc = 1'b1;
         d0 = D_2;
         d1 = D_0;
         d2 = D_2;
         d3 = (c == B_A8) ? D_8 : D_9;
      end else begin
         // broken or no sequence: held bytes go out as literals
         if (held_ff == jhe_pkg::HELD_E2 || held_ff == jhe_pkg::HELD_E2_80) begin
            data[n[jhe_pkg::JOB_IDX_W-1:0]] = B_E2;
            n = n + 1'b1;
         end
         if (held_ff == jhe_pkg::HELD_E2_80) begin
            data[n[jhe_pkg::JOB_IDX_W-1:0]] = B_80;
            n = n + 1'b1;
         end
         held_mid = jhe_pkg::HELD_NONE;
         if (html_enable && c == B_LT) begin
            esc = 1'b1;
            d2 = D_3;
            d3 = D_C;
         end else if (html_enable && c == B_GT) begin
            esc = 1'b1;
            d2 = D_3;
            d3 = D_E;
         end else if (html_enable && c == B_AMP) begin
            esc = 1'b1;
         end else if (js_enable && c == B_E2) begin
            held_mid = jhe_pkg::HELD_E2;
         end else begin
            literal = 1'b1;
         end
      end
      if (esc) begin
         data[n[jhe_pkg::JOB_IDX_W-1:0]] = B_BSLASH;
         n = n + 1'b1;
         data[n[jhe_pkg::JOB_IDX_W-1:0]] = B_U;
         n = n + 1'b1;
         data[n[jhe_pkg::JOB_IDX_W-1:0]] = d0;
         n = n + 1'b1;
         data[n[jhe_pkg::JOB_IDX_W-1:0]] = d1;
         n = n + 1'b1;
         data[n[jhe_pkg::JOB_IDX_W-1:0]] = d2;
         n = n + 1'b1;
         data[n[jhe_pkg::JOB_IDX_W-1:0]] = d3;
         n = n + 1'b1;
      end
      if (literal) begin
         data[n[jhe_pkg::JOB_IDX_W-1:0]] = c;
         n = n + 1'b1;
      end
      // end of string flushes whatever is still held
      if (fin && (held_mid == jhe_pkg::HELD_E2 || held_mid == jhe_pkg::HELD_E2_80)) begin
         data[n[jhe_pkg::JOB_IDX_W-1:0]] = B_E2;
         n = n + 1'b1;
      end
      if (fin && held_mid == jhe_pkg::HELD_E2_80) begin
         data[n[jhe_pkg::JOB_IDX_W-1:0]] = B_80;
         n = n + 1'b1;
      end
   end

   always_comb begin
      held_in = held_ff;
      any_in  = any_ff;
      if (accept) begin
         held_in = fin ? jhe_pkg::HELD_NONE : held_mid;
         any_in  = fin ? 1'b0 : (any_ff | esc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= jhe_pkg::HELD_NONE;
         any_ff  <= 1'b0;
      end else begin
         held_ff <= held_in;
         any_ff  <= any_in;
      end
   end

   assign job.data    = data;
   assign job.count   = n;
   assign job.fin     = fin;
   assign job.changed = any_ff | esc;
   assign job_push    = accept && (n != '0);

   assign status.held        = held_ff;
   assign status.any_escaped = any_ff;

endmodule

// File: src/jhe_queue.sv
// jhe_queue: short job queue between the front and the back
// depends on jhe_pkg for the job type
module jhe_queue #(
   parameter int Depth = jhe_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  jhe_pkg::job_type          push_job,
   input  logic                      pop,
   output jhe_pkg::job_type          head_job,
   output logic                      head_valid,
   output logic                      full,
   output logic [$clog2(Depth+1)-1:0] level
);

   localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int LevelW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0]   PtrLast = PtrW'(Depth - 1);
   localparam logic [LevelW-1:0] LevelFull = LevelW'(Depth);

   jhe_pkg::job_type mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LevelW-1:0] level_ff, level_in;
   logic              do_push, do_pop;

   assign do_push = push && (level_ff != LevelFull);
   assign do_pop  = pop && (level_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job   = mem_ff[rd_ptr_ff];
   assign head_valid = (level_ff != '0);
   assign full       = (level_ff == LevelFull);
   assign level      = level_ff;

endmodule

// File: src/jhe_back.sv
// jhe_back: walks the head job byte by byte onto the result channel
// depends on jhe_pkg
module jhe_back (
   input  logic             clock,
   input  logic             reset,
   input  jhe_pkg::job_type head_job,
   input  logic             head_valid,
   output logic             head_pop,
   input  logic             pop,
   output logic             empty,
   output jhe_pkg::rsp_type rsp_item
);

   logic [jhe_pkg::JOB_IDX_W-1:0] idx_ff, idx_in;
   logic                          last;
   logic                          take;

   assign last = ({1'b0, idx_ff} + 1'b1) == head_job.count;
   assign take = pop && head_valid;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   assign head_pop = take && last;
   assign empty    = !head_valid;

   assign rsp_item.out_byte   = head_job.data[idx_ff];
   assign rsp_item.run_end    = last;
   assign rsp_item.string_end = last && head_job.fin;
   assign rsp_item.changed    = last && head_job.fin && head_job.changed;

endmodule
